>>> design/radix_half_weight_split_core_macros.svh
// assertion macros for the radix half weight split core
// used by the top level only, no other dependencies
`ifndef RADIX_HALF_WEIGHT_SPLIT_CORE_MACROS_SVH
`define RADIX_HALF_WEIGHT_SPLIT_CORE_MACROS_SVH

// same-cycle implication under synchronous reset
`define RHWS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rhws assertion failed");

// next-cycle implication under synchronous reset
`define RHWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rhws assertion failed");

`endif

>>> design/rhws_pkg.sv
// shared constants and types for the radix half weight split core
// no dependencies
package rhws_pkg;

   localparam int FIELD_WIDTH   = 64;
   localparam int VALUE_WIDTH   = 64;
   localparam int MAX_DIGITS    = 64;
   localparam int DIGIT_WIDTH   = 8;
   localparam int COUNT_WIDTH   = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_WIDTH    = $clog2(MAX_DIGITS);
   localparam int DIV_CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int MAC_CNT_WIDTH = $clog2(DIGIT_WIDTH);

   localparam logic [DIGIT_WIDTH-1:0] RADIX_RESET = 8'd2;
   localparam logic [DIGIT_WIDTH-1:0] RADIX_MIN   = 8'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_CHECK,
      ST_DIV_WAIT,
      ST_SUM_SETUP,
      ST_SUM_READ,
      ST_SUM_START,
      ST_SUM_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic req_ready;
      logic div_start;
      logic ram_we;
      logic ram_re;
      logic mac_start;
      logic rsp_load;
   } ctrl_type;

endpackage

>>> design/rhws_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module rhws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/rhws_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on rhws_pkg
module rhws_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rhws_pkg::VALUE_WIDTH-1:0]  dividend,
   input  logic [rhws_pkg::DIGIT_WIDTH-1:0]  divisor,
   output logic                              done,
   output logic [rhws_pkg::VALUE_WIDTH-1:0]  quotient,
   output logic [rhws_pkg::DIGIT_WIDTH-1:0]  remainder
);
   import rhws_pkg::*;

   logic [VALUE_WIDTH-1:0]   q_ff, q_in;
   logic [DIGIT_WIDTH-1:0]   r_ff, r_in;
   logic [DIGIT_WIDTH-1:0]   d_ff, d_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIGIT_WIDTH:0]     trial;
   logic [DIGIT_WIDTH:0]     diff;
   logic                     fits;

   always_comb begin
      trial = {r_ff, q_ff[VALUE_WIDTH-1]};
      diff  = trial - {1'b0, d_ff};
      fits  = (trial >= {1'b0, d_ff});
   end

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in   = fits ? diff[DIGIT_WIDTH-1:0] : trial[DIGIT_WIDTH-1:0];
         q_in   = {q_ff[VALUE_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

>>> design/rhws_mac.sv
// bit-serial shift-add unit: power times digit and power times base together
// depends on rhws_pkg
module rhws_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rhws_pkg::VALUE_WIDTH-1:0]  power,
   input  logic [rhws_pkg::DIGIT_WIDTH-1:0]  digit,
   input  logic [rhws_pkg::DIGIT_WIDTH-1:0]  base,
   output logic                              done,
   output logic [rhws_pkg::VALUE_WIDTH-1:0]  term,
   output logic [rhws_pkg::VALUE_WIDTH-1:0]  power_next
);
   import rhws_pkg::*;

   logic [VALUE_WIDTH-1:0]   pw_ff, pw_in;
   logic [DIGIT_WIDTH-1:0]   dg_ff, dg_in;
   logic [DIGIT_WIDTH-1:0]   bs_ff, bs_in;
   logic [VALUE_WIDTH-1:0]   term_ff, term_in;
   logic [VALUE_WIDTH-1:0]   pnext_ff, pnext_in;
   logic [MAC_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   always_comb begin
      pw_in    = pw_ff;
      dg_in    = dg_ff;
      bs_in    = bs_ff;
      term_in  = term_ff;
      pnext_in = pnext_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         pw_in    = power;
         dg_in    = digit;
         bs_in    = base;
         term_in  = '0;
         pnext_in = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (dg_ff[0]) begin
            term_in = term_ff + pw_ff;
         end
         if (bs_ff[0]) begin
            pnext_in = pnext_ff + pw_ff;
         end
         pw_in  = {pw_ff[VALUE_WIDTH-2:0], 1'b0};
         dg_in  = {1'b0, dg_ff[DIGIT_WIDTH-1:1]};
         bs_in  = {1'b0, bs_ff[DIGIT_WIDTH-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MAC_CNT_WIDTH'(DIGIT_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      pw_ff    <= pw_in;
      dg_ff    <= dg_in;
      bs_ff    <= bs_in;
      term_ff  <= term_in;
      pnext_ff <= pnext_in;
      cnt_ff   <= cnt_in;
   end

   assign done       = done_ff;
   assign term       = term_ff;
   assign power_next = pnext_ff;

endmodule

>>> design/radix_half_weight_split_core.sv
// top level of the radix half weight split core
// depends on rhws_pkg, rhws_ram, rhws_divider, rhws_mac and the macros header
//
// usage:
//   csr_valid/csr_ready/csr_radix write the base (reset value 2, values below
//   two act as two); csr_ready is always high, write only while idle.
//   req_valid/req_ready/req_value take one item; req_ready is high only while
//   no item is in work. rsp_valid/rsp_ready/rsp_low_part return one item per
//   input item, from an output register, so the next item is taken while a
//   result still waits.
// passes:
//   digit pass: one divider run per digit of the value, with the bit-serial
//   divider giving one quotient bit per cycle over the value width.
//   sum pass: per digit up to the stopping digit, a registered digit ram read
//   and then a run of the bit-serial shift-add unit.
//   rsp_valid rises once the sum pass ends at the stopping digit (both passes
//   are skipped for a zero value); a new item is taken only back in idle.
// reset: synchronous, active high; clears control state and the radix register.
//   the digit ram is not cleared, only digits of the current item are read.
// stall: a result held by rsp_ready low keeps its value; a finished item then
//   waits in its last state until the output register is free.
`include "radix_half_weight_split_core_macros.svh"

module radix_half_weight_split_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rhws_pkg::FIELD_WIDTH-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rhws_pkg::FIELD_WIDTH-1:0]  rsp_low_part,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rhws_pkg::DIGIT_WIDTH-1:0]  csr_radix
);
   import rhws_pkg::*;

   state_type              state_ff, state_in;
   ctrl_type               ctrl;
   logic [DIGIT_WIDTH-1:0] radix_ff, radix_in;
   logic [DIGIT_WIDTH-1:0] base_ff, base_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] weight_ff, weight_in;
   logic [COUNT_WIDTH-1:0] target_ff, target_in;
   logic [COUNT_WIDTH-1:0] seen_ff, seen_in;
   logic [COUNT_WIDTH-1:0] idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] power_ff, power_in;
   logic [VALUE_WIDTH-1:0] sum_ff, sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                   div_done;
   logic [VALUE_WIDTH-1:0] div_quot;
   logic [DIGIT_WIDTH-1:0] div_rem;
   logic [DIGIT_WIDTH-1:0] ram_rdata;
   logic                   mac_done;
   logic [VALUE_WIDTH-1:0] mac_term;
   logic [VALUE_WIDTH-1:0] mac_power;

   logic                   digits_done;
   logic                   rsp_free;
   logic [COUNT_WIDTH-1:0] seen_next;
   logic                   stop;

   rhws_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.div_start),
      .dividend  (quot_ff),
      .divisor   (base_ff),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   rhws_ram #(
      .WIDTH (DIGIT_WIDTH),
      .DEPTH (MAX_DIGITS)
   ) u_digit_store (
      .clock (clock),
      .we    (ctrl.ram_we),
      .waddr (count_ff[ADDR_WIDTH-1:0]),
      .wdata (div_rem),
      .re    (ctrl.ram_re),
      .raddr (idx_ff[ADDR_WIDTH-1:0]),
      .rdata (ram_rdata)
   );

   rhws_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .start      (ctrl.mac_start),
      .power      (power_ff),
      .digit      (ram_rdata),
      .base       (base_ff),
      .done       (mac_done),
      .term       (mac_term),
      .power_next (mac_power)
   );

   always_comb begin
      digits_done = (quot_ff == '0) || (count_ff == COUNT_WIDTH'(MAX_DIGITS));
      rsp_free    = !rsp_valid_ff || rsp_ready;
      seen_next   = seen_ff + COUNT_WIDTH'(ram_rdata != '0);
      stop        = (seen_next >= target_ff) || ((idx_ff + 1'b1) == count_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIV_CHECK;
            end
         end
         ST_DIV_CHECK: begin
            state_in = digits_done ? ST_SUM_SETUP : ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_DIV_CHECK;
            end
         end
         ST_SUM_SETUP: begin
            state_in = (count_ff == '0) ? ST_DONE : ST_SUM_READ;
         end
         ST_SUM_READ: begin
            state_in = ST_SUM_START;
         end
         ST_SUM_START: begin
            state_in = ST_SUM_WAIT;
         end
         ST_SUM_WAIT: begin
            if (mac_done) begin
               state_in = stop ? ST_DONE : ST_SUM_READ;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control strobes
   always_comb begin
      ctrl           = '0;
      ctrl.req_ready = (state_ff == ST_IDLE);
      ctrl.div_start = (state_ff == ST_DIV_CHECK) && !digits_done;
      ctrl.ram_we    = (state_ff == ST_DIV_WAIT) && div_done;
      ctrl.ram_re    = (state_ff == ST_SUM_READ);
      ctrl.mac_start = (state_ff == ST_SUM_START);
      ctrl.rsp_load  = (state_ff == ST_DONE) && rsp_free;
   end

   always_comb begin
      radix_in     = radix_ff;
      base_in      = base_ff;
      quot_in      = quot_ff;
      count_in     = count_ff;
      weight_in    = weight_ff;
      target_in    = target_ff;
      seen_in      = seen_ff;
      idx_in       = idx_ff;
      power_in     = power_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         radix_in = csr_radix;
      end
      if (ctrl.req_ready && req_valid) begin
         quot_in   = req_value[VALUE_WIDTH-1:0];
         count_in  = '0;
         weight_in = '0;
         base_in   = (radix_ff < RADIX_MIN) ? RADIX_MIN : radix_ff;
      end
      if (ctrl.ram_we) begin
         quot_in   = div_quot;
         count_in  = count_ff + 1'b1;
         weight_in = weight_ff + COUNT_WIDTH'(div_rem != '0);
      end
      if (state_ff == ST_SUM_SETUP) begin
         idx_in    = '0;
         seen_in   = '0;
         power_in  = VALUE_WIDTH'(1);
         sum_in    = '0;
         target_in = weight_ff >> 1;
      end
      if ((state_ff == ST_SUM_WAIT) && mac_done) begin
         seen_in  = seen_next;
         sum_in   = sum_ff + mac_term;
         power_in = mac_power;
         idx_in   = idx_ff + 1'b1;
      end
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = FIELD_WIDTH'(sum_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radix_ff     <= RADIX_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      quot_ff     <= quot_in;
      count_ff    <= count_in;
      weight_ff   <= weight_in;
      target_ff   <= target_in;
      seen_ff     <= seen_in;
      idx_ff      <= idx_in;
      power_ff    <= power_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready    = ctrl.req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_low_part = rsp_data_ff;
   assign csr_ready    = 1'b1;

   `RHWS_ASSERT_IMPLY(a_ram_in_range, clock, reset, ctrl.ram_we, count_ff < COUNT_WIDTH'(MAX_DIGITS))
   `RHWS_ASSERT_IMPLY(a_div_done_in_wait, clock, reset, div_done, state_ff == ST_DIV_WAIT)
   `RHWS_ASSERT_IMPLY(a_sum_read_bound, clock, reset, ctrl.ram_re, idx_ff < count_ff)
   `RHWS_ASSERT_NEXT(a_load_sets_valid, clock, reset, ctrl.rsp_load, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
